FILE: design/fdtw_pkg.sv
// Shared constants and types for the device-tree structure token walker.
package fdtw_pkg;

  localparam int DEPTH_BITS = 8;
  localparam int DEPTH_EXT_W = (DEPTH_BITS > 8) ? DEPTH_BITS : 8;

  localparam logic [31:0] BLOB_MAGIC   = 32'hd00dfeed;
  localparam logic [31:0] TAG_BEGIN    = 32'h1;
  localparam logic [31:0] TAG_ENDNODE  = 32'h2;
  localparam logic [31:0] TAG_PROPERTY = 32'h3;
  localparam logic [31:0] TAG_NOP      = 32'h4;
  localparam logic [31:0] TAG_END      = 32'h9;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_OPEN     = 3'd1,
    EV_CLOSE    = 3'd2,
    EV_OK       = 3'd3,
    EV_BADMAGIC = 3'd4,
    EV_BADTAG   = 3'd5
  } event_t;

  typedef struct packed {
    logic [31:0] blob_word;
    logic        first_word;
  } word_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  nesting_depth;
  } result_t;

endpackage

FILE: design/fdtw_if.sv
// Valid/ready channel interfaces for blob words and walk results.
interface fdtw_in_if;
  import fdtw_pkg::*;
  logic        valid;
  logic        ready;
  logic [31:0] blob_word;
  logic        first_word;

  modport source (output valid, output blob_word, output first_word, input ready);
  modport sink   (input valid, input blob_word, input first_word, output ready);
endinterface

interface fdtw_out_if;
  import fdtw_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] nesting_depth;

  modport source (output valid, output event_res, output nesting_depth, input ready);
  modport sink   (input valid, input event_res, input nesting_depth, output ready);
endinterface

FILE: design/fdtw_core.sv
// Walk state registers and per-word token decode.
module fdtw_core
  import fdtw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  word_t   word_in,
  output result_t result_nxt
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_TOKEN  = 3'd2,
    PH_NAME   = 3'd3,
    PH_PLEN   = 3'd4,
    PH_POFF   = 3'd5,
    PH_DATA   = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [29:0]           pos_r, pos_nxt;
  logic [29:0]           start_r, start_nxt;
  logic [30:0]           skip_r, skip_nxt;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt;
  logic [DEPTH_EXT_W-1:0] depth_ext;
  event_t                ev;
  logic [29:0]           pos_inc;
  logic [29:0]           start_raw;
  logic [30:0]           skip_dec;
  logic                  zero_byte;
  logic [31:0]           w;

  assign w         = word_in.blob_word;
  assign pos_inc   = pos_r + 30'd1;
  assign start_raw = w[31:2];
  assign skip_dec  = (skip_r != 31'd0) ? skip_r - 31'd1 : skip_r;
  assign zero_byte = (w[7:0] == 8'd0) || (w[15:8] == 8'd0) ||
                     (w[23:16] == 8'd0) || (w[31:24] == 8'd0);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    skip_nxt  = skip_r;
    depth_nxt = depth_r;
    ev        = EV_NONE;
    if (word_in.first_word) begin
      pos_nxt   = 30'd0;
      start_nxt = 30'd0;
      skip_nxt  = 31'd0;
      depth_nxt = '0;
      if (w == BLOB_MAGIC) begin
        phase_nxt = PH_HEADER;
      end else begin
        phase_nxt = PH_DONE;
        ev        = EV_BADMAGIC;
      end
    end else begin
      pos_nxt = pos_inc;
      case (phase_r)
        PH_HEADER: begin
          if (pos_inc == 30'd2) begin
            start_nxt = (start_raw < 30'd3) ? 30'd3 : start_raw;
          end
          if (({1'b0, pos_inc} + 31'd1 == {1'b0, start_nxt}) && (pos_inc >= 30'd2)) begin
            phase_nxt = PH_TOKEN;
          end
        end
        PH_TOKEN: begin
          if (w == TAG_BEGIN) begin
            depth_nxt = depth_r + DEPTH_BITS'(1);
            ev        = EV_OPEN;
            phase_nxt = PH_NAME;
          end else if (w == TAG_ENDNODE) begin
            depth_nxt = depth_r - DEPTH_BITS'(1);
            ev        = EV_CLOSE;
          end else if (w == TAG_PROPERTY) begin
            phase_nxt = PH_PLEN;
          end else if (w == TAG_NOP) begin
            phase_nxt = PH_TOKEN;
          end else if (w == TAG_END) begin
            ev        = EV_OK;
            phase_nxt = PH_DONE;
          end else begin
            ev        = EV_BADTAG;
            phase_nxt = PH_DONE;
          end
        end
        PH_NAME: begin
          if (zero_byte) begin
            phase_nxt = PH_TOKEN;
          end
        end
        PH_PLEN: begin
          skip_nxt  = 31'(({1'b0, w} + 33'd3) >> 2);
          phase_nxt = PH_POFF;
        end
        PH_POFF: begin
          phase_nxt = (skip_r == 31'd0) ? PH_TOKEN : PH_DATA;
        end
        PH_DATA: begin
          skip_nxt = skip_dec;
          if (skip_dec == 31'd0) begin
            phase_nxt = PH_TOKEN;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  assign depth_ext                = DEPTH_EXT_W'(depth_nxt);
  assign result_nxt.event_res     = ev;
  assign result_nxt.nesting_depth = depth_ext[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= 30'd0;
      start_r <= 30'd0;
      skip_r  <= 31'd0;
      depth_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      skip_r  <= skip_nxt;
      depth_r <= depth_nxt;
    end
  end

endmodule

FILE: design/fdt_structure_token_walker.sv
// Top level of the device-tree structure token walker.
//
//   channel | dir | handshake          | payload
//   in_ch   | in  | valid/ready        | blob_word[31:0], first_word
//   out_ch  | out | valid/ready        | event_res[2:0], nesting_depth[7:0]
//
// One word per cycle while the result path is not stalled; each accepted word gives one result on the next cycle.
// The result is held in the result register after the token decode.
// Synchronous active-low reset returns the walk to idle with depth zero.
// A stalled result holds in the result register; input is taken in the same
// cycle the pending result leaves.
module fdt_structure_token_walker
  import fdtw_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  fdtw_in_if.sink      in_ch,
  fdtw_out_if.source   out_ch
);

  logic    in_fire;
  logic    out_valid_r;
  word_t   word_in;
  result_t result_nxt;
  result_t result_r;

  assign in_ch.ready        = !out_valid_r || out_ch.ready;
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign word_in.blob_word  = in_ch.blob_word;
  assign word_in.first_word = in_ch.first_word;

  fdtw_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_fire),
    .word_in    (word_in),
    .result_nxt (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_res     = result_r.event_res;
  assign out_ch.nesting_depth = result_r.nesting_depth;

endmodule

FILE: design/fdtw_checker.sv
// Port-level checks for the token walker and their binding.
module fdtw_checker
  import fdtw_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_res,
  input logic [7:0] nesting_depth
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(nesting_depth))
    else $error("stalled result changed");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused while result path free");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word gave no result");

  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> event_res <= EV_BADTAG)
    else $error("event code out of range");

endmodule

bind fdt_structure_token_walker fdtw_checker u_fdtw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .event_res     (out_ch.event_res),
  .nesting_depth (out_ch.nesting_depth)
);

FILE: sim/fdtw_walk_checker.sv
// Scoreboard for the device-tree token walker: predicts each word's event and depth, compares results.
`timescale 1ns / 1ps

module fdtw_walk_checker
  import fdtw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  fdtw_in_if   in_ch,
  fdtw_out_if  out_ch,
  output int   mismatch_cnt,
  output int   pending_cnt
);

  typedef enum logic [2:0] {
    WALK_IDLE,
    WALK_HEADER,
    WALK_TOKEN,
    WALK_NAME,
    WALK_PLEN,
    WALK_POFF,
    WALK_DATA,
    WALK_DONE
  } walk_phase_t;

  walk_phase_t           phase_q;
  logic [29:0]           word_pos;
  logic [29:0]           struct_word;
  logic [30:0]           skip_left;
  logic [DEPTH_BITS-1:0] depth_q;
  result_t               walk_results_q[$];

  task automatic report_mismatch(string msg);
    $display("%0t ns: ERROR %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic result_t walk_word(logic [31:0] w, logic first);
    event_t                 ev;
    logic [29:0]            s;
    logic [32:0]            padded;
    logic [DEPTH_EXT_W-1:0] depth_ext;
    result_t                r;
    ev = EV_NONE;
    if (first) begin
      word_pos    = '0;
      struct_word = '0;
      skip_left   = '0;
      depth_q     = '0;
      if (w == BLOB_MAGIC) begin
        phase_q = WALK_HEADER;
      end else begin
        phase_q = WALK_DONE;
        ev      = EV_BADMAGIC;
      end
    end else begin
      word_pos = word_pos + 30'd1;
      case (phase_q)
        WALK_HEADER: begin
          if (word_pos == 30'd2) begin
            s = w[31:2];
            struct_word = (s < 30'd3) ? 30'd3 : s;
          end
          if (word_pos >= 30'd2 && ({1'b0, word_pos} + 31'd1) == {1'b0, struct_word}) begin
            phase_q = WALK_TOKEN;
          end
        end
        WALK_TOKEN: begin
          case (w)
            TAG_BEGIN: begin
              depth_q = depth_q + DEPTH_BITS'(1);
              ev      = EV_OPEN;
              phase_q = WALK_NAME;
            end
            TAG_ENDNODE: begin
              depth_q = depth_q - DEPTH_BITS'(1);
              ev      = EV_CLOSE;
            end
            TAG_PROPERTY: phase_q = WALK_PLEN;
            TAG_NOP: ;
            TAG_END: begin
              ev      = EV_OK;
              phase_q = WALK_DONE;
            end
            default: begin
              ev      = EV_BADTAG;
              phase_q = WALK_DONE;
            end
          endcase
        end
        WALK_NAME: begin
          if (w[7:0] == 8'h0 || w[15:8] == 8'h0 || w[23:16] == 8'h0 || w[31:24] == 8'h0) begin
            phase_q = WALK_TOKEN;
          end
        end
        WALK_PLEN: begin
          padded    = {1'b0, w} + 33'd3;
          skip_left = padded[32:2];
          phase_q   = WALK_POFF;
        end
        WALK_POFF: begin
          if (skip_left == '0) begin
            phase_q = WALK_TOKEN;
          end else begin
            phase_q = WALK_DATA;
          end
        end
        WALK_DATA: begin
          if (skip_left != '0) skip_left = skip_left - 31'd1;
          if (skip_left == '0) phase_q = WALK_TOKEN;
        end
        default: ;
      endcase
    end
    depth_ext       = DEPTH_EXT_W'(depth_q);
    r.event_res     = ev;
    r.nesting_depth = depth_ext[7:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      phase_q      = WALK_IDLE;
      word_pos     = '0;
      struct_word  = '0;
      skip_left    = '0;
      depth_q      = '0;
      mismatch_cnt = 0;
      walk_results_q.delete();
    end else begin
      // compare before predicting: a result never belongs to a word taken on the same edge
      if (out_ch.valid && out_ch.ready) begin
        if (walk_results_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: event %0d depth %0d",
                                    out_ch.event_res, out_ch.nesting_depth));
        end else begin
          want = walk_results_q.pop_front();
          if (out_ch.event_res !== want.event_res) begin
            report_mismatch($sformatf("event_res got %0d expected %0d",
                                      out_ch.event_res, want.event_res));
          end
          if (out_ch.nesting_depth !== want.nesting_depth) begin
            report_mismatch($sformatf("nesting_depth got %0d expected %0d",
                                      out_ch.nesting_depth, want.nesting_depth));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        walk_results_q.push_back(walk_word(in_ch.blob_word, in_ch.first_word));
      end
    end
    pending_cnt <= walk_results_q.size();
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the device-tree token walker: blob stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps

module tb_top;
  import fdtw_pkg::*;

  localparam int LONG_HOLD  = 400;
  localparam int WORD_COUNT = 1750;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fdtw_in_if  in_ch ();
  fdtw_out_if out_ch ();

  int     mismatch_cnt;
  int     pending_cnt;
  int     results_seen = 0;
  int     words_sent   = 0;
  int     blobs_sent   = 0;
  int     good_blobs   = 0;
  int     calm_in      = 0;
  bit     deep_done    = 1'b0;
  word_t  blob_q[$];

  always #1 clk = ~clk;

  fdt_structure_token_walker i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fdtw_walk_checker i_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatch_cnt (mismatch_cnt),
    .pending_cnt  (pending_cnt)
  );

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) results_seen <= results_seen + 1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_word(logic [31:0] w, logic f);
    blob_q.push_back({w, f});
  endfunction

  function automatic void add_header();
    int         start;
    logic [1:0] low;
    start = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
    low   = ($urandom_range(0, 4) == 0) ? 2'($urandom) : 2'b00;
    push_word(BLOB_MAGIC, 1'b1);
    push_word($urandom, 1'b0);
    push_word({30'(start), low}, 1'b0);
    for (int p = 3; p < start; p++) push_word($urandom, 1'b0);
  endfunction

  function automatic void add_name();
    logic [31:0] w;
    int          k;
    repeat ($urandom_range(0, 3)) begin
      w = $urandom;
      while (w[7:0] == 8'h0 || w[15:8] == 8'h0 || w[23:16] == 8'h0 || w[31:24] == 8'h0) begin
        w = $urandom;
      end
      push_word(w, 1'b0);
    end
    w = $urandom;
    k = $urandom_range(0, 3);
    push_word(w & ~(32'hff << (8 * k)), 1'b0);
  endfunction

  function automatic void add_prop();
    int len;
    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
    push_word(TAG_PROPERTY, 1'b0);
    push_word(32'(len), 1'b0);
    push_word($urandom, 1'b0);
    repeat ((len + 3) / 4) push_word($urandom, 1'b0);
  endfunction

  function automatic void add_node(int lvl);
    push_word(TAG_BEGIN, 1'b0);
    add_name();
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 4) == 0) push_word(TAG_NOP, 1'b0);
      add_prop();
    end
    if (lvl < 3) begin
      repeat ($urandom_range(0, (lvl == 0) ? 3 : 2)) add_node(lvl + 1);
    end
    push_word(TAG_ENDNODE, 1'b0);
  endfunction

  function automatic void add_struct();
    if ($urandom_range(0, 9) == 0) push_word(TAG_ENDNODE, 1'b0);
    repeat ($urandom_range(0, 2)) push_word(TAG_NOP, 1'b0);
    add_node(0);
    push_word(TAG_END, 1'b0);
    if ($urandom_range(0, 2) == 0) push_word($urandom, 1'b0);
  endfunction

  task automatic put_word(logic [31:0] w, logic f);
    int gap;
    if (calm_in > 0) begin
      calm_in--;
      gap = 0;
    end else begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.blob_word  <= w;
    in_ch.first_word <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic flush_blob();
    foreach (blob_q[i]) put_word(blob_q[i].blob_word, blob_q[i].first_word);
    blob_q.delete();
    blobs_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  task automatic directed_blobs();
    // words before any header, then a bad magic and a word after it
    push_word($urandom, 1'b0);
    push_word(32'hffffffff, 1'b0);
    push_word(BLOB_MAGIC ^ 32'h1, 1'b1);
    push_word(TAG_BEGIN, 1'b0);
    // misaligned offset inside the header, underflow, props, nop, bad tag
    push_word(BLOB_MAGIC, 1'b1);
    push_word(32'h00000100, 1'b0);
    push_word(32'h0000000d, 1'b0);
    push_word(TAG_ENDNODE, 1'b0);
    push_word(TAG_BEGIN, 1'b0);
    push_word(32'h6e6f6400, 1'b0);
    push_word(TAG_PROPERTY, 1'b0);
    push_word(32'd5, 1'b0);
    push_word(32'h00000010, 1'b0);
    push_word(32'h12345678, 1'b0);
    push_word(32'h9abcdef0, 1'b0);
    push_word(TAG_PROPERTY, 1'b0);
    push_word(32'd0, 1'b0);
    push_word(32'h00000000, 1'b0);
    push_word(TAG_NOP, 1'b0);
    push_word(32'h00000005, 1'b0);
    push_word(TAG_END, 1'b0);
    // restart mid-walk, offset past the header with filler, clean end
    push_word(BLOB_MAGIC, 1'b1);
    push_word(32'h0, 1'b0);
    push_word(32'h00000008, 1'b0);
    push_word(TAG_BEGIN, 1'b0);
    push_word(BLOB_MAGIC, 1'b1);
    push_word(32'h0, 1'b0);
    push_word(32'h00000014, 1'b0);
    push_word($urandom, 1'b0);
    push_word($urandom, 1'b0);
    push_word(TAG_END, 1'b0);
    push_word(TAG_BEGIN, 1'b0);
    flush_blob();
  endtask

  task automatic random_blob();
    int    r;
    int    i;
    int    keep;
    word_t wd;
    r = $urandom_range(0, 99);
    if (!deep_done && words_sent > 500) begin
      // nest past the depth counter's width
      deep_done = 1'b1;
      add_header();
      repeat (257) begin
        push_word(TAG_BEGIN, 1'b0);
        push_word($urandom & 32'hffff00ff, 1'b0);
      end
      repeat (3) push_word(TAG_ENDNODE, 1'b0);
      push_word(TAG_END, 1'b0);
    end else if (r < 85) begin
      add_header();
      add_struct();
      if (r < 70) begin
        good_blobs++;
      end else begin
        i  = $urandom_range(3, blob_q.size() - 1);
        wd = blob_q[i];
        wd.blob_word = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
        blob_q[i] = wd;
        if ($urandom_range(0, 1) == 0) begin
          keep = i + 1 + $urandom_range(0, 3);
          while (blob_q.size() > keep) void'(blob_q.pop_back());
        end
      end
    end else if (r < 93) begin
      repeat ($urandom_range(1, 8)) begin
        push_word(($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15)) : $urandom,
                  $urandom_range(0, 9) == 0);
      end
    end else begin
      push_word(($urandom_range(0, 1) == 0) ? (BLOB_MAGIC ^ (32'h1 << $urandom_range(0, 31)))
                                            : $urandom, 1'b1);
      repeat ($urandom_range(0, 4)) push_word($urandom, 1'b0);
    end
    if ($urandom_range(0, 99) < 15) calm_in = blob_q.size();
    flush_blob();
  endtask

  initial begin
    int gap;
    int calm_out;
    bit held;
    calm_out = 0;
    held     = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && results_seen >= 700) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (calm_out > 0) begin
        calm_out--;
        gap = 0;
      end else begin
        gap = pick_gap();
        if ($urandom_range(0, 99) < 2) calm_out = $urandom_range(30, 120);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    bit paused;
    paused = 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.blob_word  <= '0;
    in_ch.first_word <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    directed_blobs();
    drain();
    while (words_sent < WORD_COUNT) begin
      random_blob();
      if (!paused && words_sent > 1200) begin
        paused = 1'b1;
        drain();
      end
    end
    drain();
    repeat (20) @(posedge clk);
    $display("Streamed %0d words in %0d blobs, %0d well-formed walks; %0d results compared",
             words_sent, blobs_sent, good_blobs, results_seen);
    $display("Covered bad magic and tags, restarts, depth wrap both ways and a %0d-cycle hold",
             LONG_HOLD);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
design/fdtw_pkg.sv
design/fdtw_if.sv
design/fdtw_core.sv
design/fdt_structure_token_walker.sv
design/fdtw_checker.sv
sim/fdtw_walk_checker.sv
sim/tb_top.sv
